// ===== sv/dgcdt_pkg.sv =====
// Shared types and constants for the discrete Gaussian CDT sampler.
package dgcdt_pkg;

  localparam int WORD_W  = 32;  // table entries, uniform word, half weight
  localparam int MOD_W   = 64;  // ring modulus and residue
  localparam int VAL_W   = 9;   // signed sample value
  localparam int EIU_W   = 8;   // entries_in_use register
  localparam int SLOT_W  = 7;   // entry_index field
  localparam int PADDR_W = 5;   // three registers at 8-byte spacing
  localparam int PDATA_W = 64;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    REG_CHW     = 2'd0,
    REG_MODULUS = 2'd1,
    REG_EIU     = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CHECK = 3'b010,
    S_SCAN  = 3'b100
  } scan_state_t;

  // search result handed to the output stage
  typedef struct packed {
    logic done;
    logic neg;
    logic last;
  } scan_res_t;

endpackage

// ===== sv/dgcdt_table.sv =====
// Cumulative probability table: one write port, one registered read port.
module dgcdt_table import dgcdt_pkg::*; #(
  parameter int TABLE_DEPTH = 128
) (
  input  logic                           clk,
  input  logic                           wr_en_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr_i,
  input  logic [WORD_W-1:0]              wr_data_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr_i,
  output logic [WORD_W-1:0]              rd_data_o
);

  logic [WORD_W-1:0] mem [TABLE_DEPTH];
  logic [WORD_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_r;

endmodule

// ===== sv/dgcdt_scan.sv =====
// Search sequencer: magnitude, center test and linear scan of the table.
module dgcdt_scan import dgcdt_pkg::*; #(
  parameter int TABLE_DEPTH = 128
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             go_i,
  input  logic [WORD_W-1:0]                word_i,
  input  logic                             last_i,
  input  logic [WORD_W-1:0]                chw_i,
  input  logic [EIU_W-1:0]                 eiu_i,
  output logic [$clog2(TABLE_DEPTH)-1:0]   rd_addr_o,
  input  logic [WORD_W-1:0]                rd_data_i,
  output logic                             busy_o,
  output scan_res_t                        res_o,
  output logic [$clog2(TABLE_DEPTH+1)-1:0] mag_o
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  scan_state_t       state_r, state_nxt;
  logic [WORD_W-1:0] val_r, val_nxt;     // magnitude, then search target
  logic [AW-1:0]     idx_r, idx_nxt;     // slot whose data is on rd_data_i
  logic              neg_r, neg_nxt;
  logic              last_r, last_nxt;
  logic [CW-1:0]     len;
  logic [CW-1:0]     nxt;
  logic              hit;

  // table length: entries_in_use clamped to the depth
  always_comb begin
    if (32'(eiu_i) > 32'(TABLE_DEPTH)) begin
      len = CW'(TABLE_DEPTH);
    end else begin
      len = CW'(eiu_i);
    end
  end

  assign nxt = CW'(idx_r) + CW'(1);
  assign hit = (rd_data_i >= val_r);

  // next state and datapath
  always_comb begin
    state_nxt = state_r;
    val_nxt   = val_r;
    idx_nxt   = idx_r;
    neg_nxt   = neg_r;
    last_nxt  = last_r;
    res_o     = '0;
    mag_o     = '0;
    unique case (state_r)
      S_IDLE: begin
        if (go_i) begin
          neg_nxt   = word_i[WORD_W-1];
          val_nxt   = word_i[WORD_W-1] ? (WORD_W'(0) - word_i) : word_i;
          last_nxt  = last_i;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        // inside the center, or empty table: sample is zero
        if (val_r <= chw_i || len == '0) begin
          res_o     = '{done: 1'b1, neg: neg_r, last: last_r};
          state_nxt = S_IDLE;
        end else begin
          val_nxt   = val_r - chw_i;
          idx_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // hit or end of table both give magnitude idx + 1
        if (hit || nxt == len) begin
          res_o     = '{done: 1'b1, neg: neg_r, last: last_r};
          mag_o     = nxt;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = AW'(nxt);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // slot 0 is fetched during the center test, then one slot ahead
  assign rd_addr_o = (state_r == S_CHECK) ? '0 : AW'(nxt);
  assign busy_o    = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    idx_r  <= idx_nxt;
    neg_r  <= neg_nxt;
    last_r <= last_nxt;
  end

  // checks
  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_o.done |=> state_r == S_IDLE)
    else $error("scan: result without return to idle");

  a_mag_bound: assert property (@(posedge clk) disable iff (!rst_n)
    res_o.done |-> mag_o <= len)
    else $error("scan: magnitude above table length");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> CW'(idx_r) < len)
    else $error("scan: slot index beyond table length");

  a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
    go_i |-> state_r == S_IDLE)
    else $error("scan: start while busy");

endmodule

// ===== sv/discrete_gaussian_cdt_sampler.sv =====
// Top level: CDT discrete Gaussian sampler with register port and result stage.
//
//  channel | signals                                           | direction
//  --------+---------------------------------------------------+----------
//  input   | start, busy, in_opcode, in_entry_index,           | in
//          | in_entry_value, in_random_word, in_final_sample   |
//  result  | out_strobe, out_sample_value, out_sample_residue, | out
//          | out_final_mark                                    |
//  config  | psel, penable, pwrite, paddr, pwdata, prdata,     | in/out
//          | pready                                            |
//
// A load item is written in the cycle it is taken; busy stays low.
// A sample item holds busy through the center test and the scan of its slots (at most
// the table length), one table read per cycle; its result strobes in the cycle after.
// Reset returns control state and registers to their reset values; the table is not cleared.
// The result is shown for one cycle only; nothing stalls the block.
module discrete_gaussian_cdt_sampler import dgcdt_pkg::*; #(
  parameter int TABLE_DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // input channel
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_opcode,
  input  logic [SLOT_W-1:0]        in_entry_index,
  input  logic [WORD_W-1:0]        in_entry_value,
  input  logic signed [WORD_W-1:0] in_random_word,
  input  logic                     in_final_sample,
  // result channel
  output logic                     out_strobe,
  output logic signed [VAL_W-1:0]  out_sample_value,
  output logic [MOD_W-1:0]         out_sample_residue,
  output logic                     out_final_mark,
  // configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [PDATA_W-1:0]       pwdata,
  output logic [PDATA_W-1:0]       prdata,
  output logic                     pready
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [WORD_W-1:0] chw_r;
  logic [MOD_W-1:0]  modulus_r;
  logic [EIU_W-1:0]  eiu_r;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;

  logic              accept;
  logic              load_wr;
  logic              go;
  logic [AW-1:0]     rd_addr;
  logic [WORD_W-1:0] rd_data;
  scan_res_t         res;
  logic [CW-1:0]     mag;
  logic [VAL_W-1:0]  mag_val;

  logic                     strobe_r;
  logic signed [VAL_W-1:0]  value_r;
  logic [MOD_W-1:0]         residue_r;
  logic                     final_r;

  // register port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[4:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chw_r     <= '0;
      modulus_r <= MOD_W'(2);
      eiu_r     <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_CHW:     chw_r     <= pwdata[WORD_W-1:0];
        REG_MODULUS: modulus_r <= pwdata;
        REG_EIU:     eiu_r     <= pwdata[EIU_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_CHW:     prdata = PDATA_W'(chw_r);
      REG_MODULUS: prdata = modulus_r;
      REG_EIU:     prdata = PDATA_W'(eiu_r);
      default:     prdata = '0;
    endcase
  end

  // item decode
  assign accept  = start && !busy;
  assign load_wr = accept && (in_opcode == OP_LOAD)
                   && (32'(in_entry_index) < 32'(TABLE_DEPTH));
  assign go      = accept && (in_opcode == OP_SAMPLE);

  dgcdt_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
    .clk       (clk),
    .wr_en_i   (load_wr),
    .wr_addr_i (AW'(in_entry_index)),
    .wr_data_i (in_entry_value),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  dgcdt_scan #(.TABLE_DEPTH(TABLE_DEPTH)) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .go_i      (go),
    .word_i    ($unsigned(in_random_word)),
    .last_i    (in_final_sample),
    .chw_i     (chw_r),
    .eiu_i     (eiu_r),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .busy_o    (busy),
    .res_o     (res),
    .mag_o     (mag)
  );

  // result stage: sign and residue
  assign mag_val = VAL_W'(mag);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= res.done;
    end
  end

  always_ff @(posedge clk) begin
    if (res.done) begin
      value_r <= res.neg ? $signed(VAL_W'(0) - mag_val) : $signed(mag_val);
      final_r <= res.last;
      if (mag == '0) begin
        residue_r <= '0;
      end else if (res.neg) begin
        residue_r <= modulus_r - MOD_W'(mag);
      end else begin
        residue_r <= MOD_W'(mag);
      end
    end
  end

  assign out_strobe         = strobe_r;
  assign out_sample_value   = value_r;
  assign out_sample_residue = residue_r;
  assign out_final_mark     = final_r;

  // checks
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("top: results on consecutive cycles");

  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("top: result without a sample in flight");

  a_eiu_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr && cfg_idx == REG_EIU |=> eiu_r == $past(pwdata[EIU_W-1:0]))
    else $error("top: entries_in_use write lost");

endmodule

// ===== verif/dgcdt_checker.sv =====
// Scoreboard for the CDT sampler: mirrors registers and table, predicts and checks samples.
`timescale 1ns / 100ps

module dgcdt_checker import dgcdt_pkg::*; #(
  parameter int TABLE_DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // input channel
  input  logic                     start,
  input  logic                     busy,
  input  logic                     in_opcode,
  input  logic [SLOT_W-1:0]        in_entry_index,
  input  logic [WORD_W-1:0]        in_entry_value,
  input  logic signed [WORD_W-1:0] in_random_word,
  input  logic                     in_final_sample,
  // result channel
  input  logic                     out_strobe,
  input  logic signed [VAL_W-1:0]  out_sample_value,
  input  logic [MOD_W-1:0]         out_sample_residue,
  input  logic                     out_final_mark,
  // register port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [PDATA_W-1:0]       pwdata,
  input  logic                     pready,
  // status to the test
  output int                       fail_count,
  output int                       pending
);

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [MOD_W-1:0]        residue;
    logic                    last;
  } draw_t;

  logic [WORD_W-1:0] cdf_mirror [TABLE_DEPTH];
  logic [WORD_W-1:0] half_weight;
  logic [MOD_W-1:0]  modulus;
  logic [EIU_W-1:0]  eiu;
  draw_t             draws_due [$];

  // expected draw for one sample item, from the mirrored state
  function automatic draw_t predict_draw(logic [WORD_W-1:0] word, logic fin);
    draw_t             d;
    logic              neg;
    logic [WORD_W-1:0] mag_in;
    logic [WORD_W-1:0] target;
    int                len;
    int                mag;
    logic              found;
    neg    = word[WORD_W-1];
    mag_in = neg ? (0 - word) : word;
    mag    = 0;
    if (mag_in > half_weight) begin
      target = mag_in - half_weight;
      len    = (eiu < TABLE_DEPTH) ? int'(eiu) : TABLE_DEPTH;
      mag    = len;
      found  = 1'b0;
      for (int i = 0; i < len; i++) begin
        if (!found && cdf_mirror[i] >= target) begin
          mag   = i + 1;
          found = 1'b1;
        end
      end
    end
    if (mag == 0) begin
      d.value   = '0;
      d.residue = '0;
    end else if (neg) begin
      d.value   = -VAL_W'(mag);
      d.residue = modulus - MOD_W'(mag);
    end else begin
      d.value   = VAL_W'(mag);
      d.residue = MOD_W'(mag);
    end
    d.last = fin;
    return d;
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    draw_t d;
    if (!rst_n) begin
      half_weight = '0;
      modulus     = MOD_W'(2);
      eiu         = '0;
      draws_due.delete();
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[PADDR_W-1:3]))
          REG_CHW:     half_weight = pwdata[WORD_W-1:0];
          REG_MODULUS: modulus     = pwdata[MOD_W-1:0];
          REG_EIU:     eiu         = pwdata[EIU_W-1:0];
          default: ;
        endcase
      end
      // accepted items
      if (start && !busy) begin
        if (opcode_t'(in_opcode) == OP_LOAD) begin
          if (in_entry_index < TABLE_DEPTH) cdf_mirror[in_entry_index] = in_entry_value;
        end else begin
          draws_due = {draws_due, predict_draw(in_random_word, in_final_sample)};
        end
      end
      // results against the oldest expectation
      if (out_strobe) begin
        if (draws_due.size() == 0) begin
          $display("%0t: unexpected sample value %0d residue %0h", $time,
                   out_sample_value, out_sample_residue);
          fail_count++;
        end else begin
          d = draws_due.pop_front();
          if (out_sample_value !== d.value) begin
            $display("%0t: sample_value expected %0d got %0d", $time, d.value,
                     out_sample_value);
            fail_count++;
          end
          if (out_sample_residue !== d.residue) begin
            $display("%0t: sample_residue expected %0h got %0h", $time, d.residue,
                     out_sample_residue);
            fail_count++;
          end
          if (out_final_mark !== d.last) begin
            $display("%0t: final_mark expected %0b got %0b", $time, d.last,
                     out_final_mark);
            fail_count++;
          end
        end
      end
    end
    pending = draws_due.size();
  end

endmodule

// ===== verif/tb_top.sv =====
// Test top for the CDT sampler: clock, reset, register setup, item stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
  import dgcdt_pkg::*;

  localparam int DEPTH      = 128;
  localparam int STALL_MAX  = 5000;  // cycles with no activity before giving up
  localparam int SETTLE_CYC = 3;     // quiet cycles before a register write
  localparam int TAIL_CYC   = 140;   // longest scan plus result stage, with margin

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic                     in_opcode;
  logic [SLOT_W-1:0]        in_entry_index;
  logic [WORD_W-1:0]        in_entry_value;
  logic signed [WORD_W-1:0] in_random_word;
  logic                     in_final_sample;
  logic                     out_strobe;
  logic signed [VAL_W-1:0]  out_sample_value;
  logic [MOD_W-1:0]         out_sample_residue;
  logic                     out_final_mark;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [PADDR_W-1:0]       paddr;
  logic [PDATA_W-1:0]       pwdata;
  logic [PDATA_W-1:0]       prdata;
  logic                     pready;
  int                       fail_count;
  int                       pending;
  int                       quiet_cycles;

  // stimulus-side view of the table, used to aim words at entry boundaries
  logic [WORD_W-1:0] cdf_shadow [DEPTH];
  bit                slot_loaded [DEPTH];
  logic [WORD_W-1:0] chw_now;
  int                len_now;
  int                idle_pct;

  discrete_gaussian_cdt_sampler #(.TABLE_DEPTH(DEPTH)) dut (.*);

  dgcdt_checker #(.TABLE_DEPTH(DEPTH)) u_checker (.*);

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog: nothing accepted for too long
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (psel && penable)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_MAX) begin
      $display("discrete_gaussian_cdt_sampler: mismatch");
      $finish;
    end
  end

  // one item: random idle gap, then hold until taken
  task automatic drive_item(opcode_t op, logic [SLOT_W-1:0] idx, logic [WORD_W-1:0] val,
                            logic [WORD_W-1:0] word, logic fin);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start           = 1'b1;
    in_opcode       = op;
    in_entry_index  = idx;
    in_entry_value  = val;
    in_random_word  = word;
    in_final_sample = fin;
    if (op == OP_LOAD) begin
      cdf_shadow[idx]  = val;
      slot_loaded[idx] = 1'b1;
    end
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drive_load(int slot, logic [WORD_W-1:0] val);
    drive_item(OP_LOAD, SLOT_W'(slot), val, $urandom, 1'($urandom));
  endtask

  task automatic drive_sample(logic [WORD_W-1:0] word, logic fin);
    drive_item(OP_SAMPLE, SLOT_W'($urandom), $urandom, word, fin);
  endtask

  // wait for all samples to drain, then SETTLE_CYC quiet cycles
  task automatic settle();
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t r, logic [PDATA_W-1:0] v);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {r, 3'b000};
    pwdata  = v;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // monotone cumulative table over slots 0..n-1, topping out near 2^31
  task automatic load_table(int n);
    logic [63:0] acc;
    logic [31:0] span;
    acc = 0;
    if (n > 0) begin
      span = 32'h8000_0000 / n;
      for (int i = 0; i < n; i++) begin
        acc = acc + $urandom_range(0, 2 * span);
        if (acc > 64'h8000_0000) acc = 64'h8000_0000;
        drive_load(i, acc[31:0]);
      end
    end
  endtask

  // sample word: random, aimed at entry boundaries, near the zero band, or extreme
  function automatic logic [WORD_W-1:0] pick_word();
    int          r;
    int          i;
    logic [31:0] m;
    r = $urandom_range(99);
    if (r < 45) return $urandom;
    if (r < 80 && len_now > 0) begin
      i = $urandom_range(len_now - 1);
      m = chw_now + cdf_shadow[i] + $urandom_range(2) - 1;
    end else if (r < 92) begin
      m = chw_now + $urandom_range(2) - 1;
    end else begin
      case ($urandom_range(3))
        0:       m = 32'h0;
        1:       m = 32'h7FFF_FFFF;
        2:       m = 32'h8000_0000;
        default: m = 32'h1;
      endcase
    end
    return $urandom_range(1) ? (0 - m) : m;
  endfunction

  // one register setting plus a burst of loads and sample vectors
  task automatic run_phase(logic [31:0] chw, logic [63:0] modv, logic [7:0] eiu, int pct,
                           int n);
    int          len;
    int          slot;
    int          vec_left;
    bit          all_loaded;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] val;
    logic        fin;
    settle();
    write_reg(REG_CHW, {32'h0, chw});
    write_reg(REG_MODULUS, modv);
    write_reg(REG_EIU, {56'h0, eiu});
    len      = (eiu > DEPTH) ? DEPTH : int'(eiu);
    chw_now  = chw;
    len_now  = len;
    idle_pct = pct;
    all_loaded = 1'b1;
    for (int i = 0; i < len; i++) if (!slot_loaded[i]) all_loaded = 1'b0;
    if (len <= 32 || !all_loaded) load_table(len);
    vec_left = 0;
    for (int k = 0; k < n; k++) begin
      // hold off once mid-phase until every sample has come back
      if (k == n / 2) settle();
      if ($urandom_range(99) < 20) begin
        slot = $urandom_range(DEPTH - 1);
        if ($urandom_range(99) < 15 || slot >= len) begin
          val = $urandom;
        end else begin
          lo = (slot == 0) ? 32'h0 : cdf_shadow[slot - 1];
          hi = (slot == len - 1) ? 32'h8000_0000 : cdf_shadow[slot + 1];
          val = (lo <= hi) ? $urandom_range(hi, lo) : $urandom;
        end
        drive_load(slot, val);
      end else begin
        if (vec_left == 0) vec_left = $urandom_range(8, 1);
        vec_left--;
        fin = (vec_left == 0);
        if ($urandom_range(19) == 0) fin = ~fin;
        drive_sample(pick_word(), fin);
      end
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_opcode       = OP_LOAD;
    in_entry_index  = '0;
    in_entry_value  = '0;
    in_random_word  = '0;
    in_final_sample = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    quiet_cycles    = 0;
    idle_pct        = 0;
    chw_now         = '0;
    len_now         = 0;
    for (int i = 0; i < DEPTH; i++) begin
      cdf_shadow[i]  = '0;
      slot_loaded[i] = 1'b0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // table length zero after reset: every draw is 0, no slot is scanned
    drive_sample(32'h0, 1'b0);
    drive_sample(32'h1, 1'b0);
    drive_sample(32'hFFFF_FFFF, 1'b0);
    drive_sample(32'h8000_0000, 1'b1);

    // small table: zero band edge, entry boundaries, both signs, saturation
    settle();
    write_reg(REG_CHW, 64'h1000_0000);
    write_reg(REG_MODULUS, '1);
    write_reg(REG_EIU, 64'd8);
    chw_now = 32'h1000_0000;
    len_now = 8;
    load_table(8);
    drive_sample(32'h0, 1'b0);
    drive_sample(chw_now, 1'b0);
    drive_sample(chw_now + 1, 1'b0);
    drive_sample(0 - (chw_now + 1), 1'b1);
    drive_sample(chw_now + cdf_shadow[3], 1'b0);
    drive_sample(chw_now + cdf_shadow[3] + 1, 1'b0);
    drive_sample(0 - (chw_now + cdf_shadow[0]), 1'b0);
    drive_sample(32'h7FFF_FFFF, 1'b0);
    drive_sample(32'h8000_0000, 1'b1);

    // random phases over register extremes and idle mixes
    run_phase($urandom_range(32'h4000_0000), {$urandom, $urandom}, 8'd8, 0, 50);
    run_phase(32'h0, 64'd2, 8'd16, 76, 50);
    run_phase(32'h8000_0000, '1, 8'd4, 16, 50);
    run_phase(32'hFFFF_FFFF, 64'd1, 8'd5, 0, 45);
    run_phase($urandom_range(32'h2000_0000), {$urandom, $urandom}, 8'd128, 16, 50);
    run_phase($urandom_range(32'h2000_0000), {$urandom, $urandom}, 8'd255, 76, 45);
    run_phase(32'h0, 64'h0, 8'd1, 0, 45);
    run_phase($urandom_range(32'h1000_0000), {$urandom, $urandom}, 8'd32, 16, 55);

    // drain, then allow for a late stray result
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYC) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("discrete_gaussian_cdt_sampler: match");
    end else begin
      $display("discrete_gaussian_cdt_sampler: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/dgcdt_pkg.sv
sv/dgcdt_table.sv
sv/dgcdt_scan.sv
sv/discrete_gaussian_cdt_sampler.sv
verif/dgcdt_checker.sv
verif/tb_top.sv
